@@ sv/swtq_pkg.sv @@
package swtq_pkg;

    localparam int WAKE_W      = 64;
    localparam int ID_W        = 8;
    localparam int DELAY_W     = 32;
    localparam int RES_W       = 2;
    localparam int MAX_RESULTS = 16;
    localparam int POP_W       = $clog2(MAX_RESULTS);

    // result codes carried on the master tuser
    localparam logic [RES_W-1:0] RES_ACCEPTED = 2'd0;
    localparam logic [RES_W-1:0] RES_FULL     = 2'd1;
    localparam logic [RES_W-1:0] RES_WOKEN    = 2'd2;

    // item kinds carried on the slave tuser
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_SLEEP = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [WAKE_W-1:0] wake;
        logic [ID_W-1:0]   id;
    } t_entry;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_DRAIN
    } t_state;

endpackage

@@ sv/swtq_cell.sv @@
module swtq_cell
    import swtq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_op    i_op,
    input  t_entry i_new,
    input  t_entry i_left,
    input  t_entry i_right,
    input  logic   i_take_left,
    output logic   o_take,
    output t_entry o_entry
);

    logic              r_valid;
    logic [WAKE_W-1:0] r_wake;
    logic [ID_W-1:0]   r_id;
    t_entry            n_entry;
    logic              n_load;

    // cell belongs to the shifted tail when empty or strictly later than the newcomer
    assign o_take  = !r_valid || (r_wake > i_new.wake);
    assign o_entry = '{valid: r_valid, wake: r_wake, id: r_id};

    always_comb begin
        n_entry = o_entry;
        n_load  = 1'b0;
        case (i_op)
            OP_INSERT: begin
                if (o_take) begin
                    n_load  = 1'b1;
                    n_entry = i_take_left ? i_left : i_new;
                end
            end
            OP_POP: begin
                n_load  = 1'b1;
                n_entry = i_right;
            end
            default: begin
                n_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_load) begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_wake <= n_entry.wake;
            r_id   <= n_entry.id;
        end
    end

endmodule

@@ sv/sorted_wakeup_timer_queue.sv @@
// Flow: a sleep request's beat is registered, then answered from ST_INSERT into the
//   output register; a tick's wakes leave from ST_DRAIN, one wake per cycle while the
//   output is free (up to 16 per tick); a tick with nobody due gives no beat.
// Input: one item at a time; no new beat is taken until the core is back in ST_IDLE.
//   The cell chain takes at most one step per cycle: one insert or one front pop.
// Reset: synchronous, active low; clears the tick count, the cell valid flags,
//   the state, the pop count and the output valid flag. No clearing pass.
module sorted_wakeup_timer_queue
    import swtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [7:0] sleeper_id, [39:8] delay_ticks
    input  logic        i_s_tuser,   // [0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [7:0] woken_id, [71:8] tick_now
    output logic [1:0]  o_m_tuser,   // [1:0] event_res
    output logic        o_m_tlast    // last_of_run
);

    t_state            r_state, n_state;
    logic [WAKE_W-1:0] r_tick;
    logic [WAKE_W-1:0] r_new_wake;
    logic [ID_W-1:0]   r_new_id;
    logic [POP_W-1:0]  r_pop_cnt;

    // output register: lets the core move on while a beat waits downstream
    logic              r_out_valid;
    logic [RES_W-1:0]  r_out_res;
    logic [ID_W-1:0]   r_out_id;
    logic [WAKE_W-1:0] r_out_tick;
    logic              r_out_last;

    // cell row; one extra always-empty slot feeds the tail on a pop
    t_entry            e_arr [0:QUEUE_DEPTH];
    logic              take_arr [0:QUEUE_DEPTH-1];
    t_entry            new_entry;

    t_op               c_op;
    logic              c_emit;
    logic [RES_W-1:0]  c_res;
    logic [ID_W-1:0]   c_id;
    logic              c_last;

    logic              s_acc;
    logic              out_free;
    logic              due0;
    logic              due1;
    logic              full;

    assign s_acc     = i_s_tvalid && o_s_tready;
    assign out_free  = !r_out_valid || i_m_tready;
    assign new_entry = '{valid: 1'b1, wake: r_new_wake, id: r_new_id};
    assign e_arr[QUEUE_DEPTH] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic take_left;
            if (gi == 0) begin : g_head
                assign take_left = 1'b0;
            end else begin : g_body
                assign take_left = take_arr[gi-1];
            end
            swtq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_op        (c_op),
                .i_new       (new_entry),
                .i_left      ((gi == 0) ? new_entry : e_arr[(gi == 0) ? 0 : gi-1]),
                .i_right     (e_arr[gi+1]),
                .i_take_left (take_left),
                .o_take      (take_arr[gi]),
                .o_entry     (e_arr[gi])
            );
        end
    endgenerate

    // front of queue is due; second entry due and still within the per-tick budget
    assign due0 = e_arr[0].valid && (e_arr[0].wake <= r_tick);
    assign due1 = e_arr[1].valid && (e_arr[1].wake <= r_tick)
               && (r_pop_cnt != POP_W'(MAX_RESULTS - 1));
    assign full = e_arr[QUEUE_DEPTH-1].valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_state = (i_s_tuser == KIND_SLEEP) ? ST_INSERT : ST_DRAIN;
                end
            end
            ST_INSERT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (!due0 || (out_free && !due1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        c_op   = OP_HOLD;
        c_emit = 1'b0;
        c_res  = RES_ACCEPTED;
        c_id   = r_new_id;
        c_last = 1'b1;
        case (r_state)
            ST_INSERT: begin
                if (out_free) begin
                    c_emit = 1'b1;
                    c_res  = full ? RES_FULL : RES_ACCEPTED;
                    c_op   = full ? OP_HOLD : OP_INSERT;
                end
            end
            ST_DRAIN: begin
                if (due0 && out_free) begin
                    c_emit = 1'b1;
                    c_res  = RES_WOKEN;
                    c_id   = e_arr[0].id;
                    c_last = !due1;
                    c_op   = OP_POP;
                end
            end
            default: begin
                c_op = OP_HOLD;
            end
        endcase
    end

    // no beat is taken while reset is held
    assign o_s_tready = i_rst_n && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tick      <= '0;
            r_pop_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_acc && (i_s_tuser == KIND_TICK)) begin
                r_tick <= r_tick + WAKE_W'(1);
            end
            if (s_acc) begin
                r_pop_cnt <= '0;
            end else if (c_op == OP_POP) begin
                r_pop_cnt <= r_pop_cnt + POP_W'(1);
            end
            if (c_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_new_wake <= r_tick + WAKE_W'(i_s_tdata[39:8]);
            r_new_id   <= i_s_tdata[7:0];
        end
        if (c_emit) begin
            r_out_res  <= c_res;
            r_out_id   <= c_id;
            r_out_tick <= r_tick;
            r_out_last <= c_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_tick, r_out_id};
    assign o_m_tuser  = r_out_res;
    assign o_m_tlast  = r_out_last;

endmodule

@@ sv/swtq_checker.sv @@
module swtq_checker
    import swtq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [39:0] i_s_tdata,
    input logic        i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // a stalled beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output beat changed while stalled");

    // one item in flight: no back-to-back accepts
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while previous item in flight");

    // request answers are single beats
    a_req_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == RES_ACCEPTED || o_m_tuser == RES_FULL) |-> o_m_tlast)
        else $error("request answer not marked last");

    // a sleep request is answered with the requester id
    a_req_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == KIND_SLEEP) && !o_m_tvalid
            |=> ##1 o_m_tvalid && (o_m_tdata[7:0] == $past(i_s_tdata[7:0], 2)))
        else $error("request answer carries wrong id");

endmodule

bind sorted_wakeup_timer_queue swtq_checker u_swtq_checker (.*);

@@ bench/tb_sorted_wakeup_timer_queue.sv @@
module tb_sorted_wakeup_timer_queue;
    import swtq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 210;
    // no beat on either side for this long means the block is stuck
    localparam int STALL_LIMIT  = 2000;
    // quiet cycles after the last wake: the core's latency plus a full drain
    localparam int TAIL_CYCLES  = 40;
    localparam int PRINT_CAP    = 40;

    // one input beat; drain_first holds it back until every answer is in
    typedef struct packed {
        logic               kind;
        logic [ID_W-1:0]    id;
        logic [DELAY_W-1:0] delay;
        logic               drain_first;
    } t_timer_cmd;

    // one output beat as the block should send it
    typedef struct packed {
        logic [RES_W-1:0]  res;
        logic [ID_W-1:0]   id;
        logic [WAKE_W-1:0] tick_now;
        logic              last;
    } t_timer_event;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata  = '0;    // [7:0] sleeper_id, [39:8] delay_ticks
    logic        i_s_tuser  = 1'b0;  // [0] kind
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;          // [7:0] woken_id, [71:8] tick_now
    logic [1:0]  o_m_tuser;          // [1:0] event_res
    logic        o_m_tlast;          // last_of_run

    sorted_wakeup_timer_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the timer queue
    // ------------------------------------------------------------------
    logic [WAKE_W-1:0] model_ticks;
    logic [WAKE_W-1:0] model_wake [QUEUE_DEPTH];
    logic [ID_W-1:0]   model_ids  [QUEUE_DEPTH];
    int                model_fill;

    t_timer_cmd   cmd_backlog[$];     // items not yet on the bus
    t_timer_event pending_events[$];  // answers the block still owes us
    t_timer_cmd   cur_cmd;            // item currently presented

    int events_predicted = 0;  // NBA-updated so driver/monitor never race
    int events_seen      = 0;
    int cmds_taken       = 0;
    int mismatch_cnt     = 0;
    int stall_cycles     = 0;
    int new_events;

    // coverage tallies, written by the predictor only
    int n_ticks    = 0;
    int n_accepted = 0;
    int n_rejected = 0;
    int n_woken    = 0;
    int max_burst  = 0;

    task automatic apply_timer_cmd(input t_timer_cmd cmd, output int produced);
        logic [WAKE_W-1:0] wake_at;
        int pos;
        int due;
        produced = 0;
        if (cmd.kind == KIND_SLEEP) begin
            if (model_fill >= QUEUE_DEPTH) begin
                pending_events.push_back('{RES_FULL, cmd.id, model_ticks, 1'b1});
                n_rejected++;
            end else begin
                // wraps mod 2^64, same as the hardware adder
                wake_at = model_ticks + WAKE_W'(cmd.delay);
                // equal wake times: newcomer goes behind earlier arrivals
                pos = 0;
                while (pos < model_fill && model_wake[pos] <= wake_at) pos++;
                for (int j = model_fill; j > pos; j--) begin
                    model_wake[j] = model_wake[j-1];
                    model_ids[j]  = model_ids[j-1];
                end
                model_wake[pos] = wake_at;
                model_ids[pos]  = cmd.id;
                model_fill++;
                pending_events.push_back('{RES_ACCEPTED, cmd.id, model_ticks, 1'b1});
                n_accepted++;
            end
            produced = 1;
        end else begin
            model_ticks = model_ticks + 1;
            n_ticks++;
            due = 0;
            while (due < model_fill && due < MAX_RESULTS && model_wake[due] <= model_ticks)
                due++;
            for (int k = 0; k < due; k++)
                pending_events.push_back('{RES_WOKEN, model_ids[k], model_ticks,
                                           (k == due - 1)});
            for (int k = 0; k + due < model_fill; k++) begin
                model_wake[k] = model_wake[k+due];
                model_ids[k]  = model_ids[k+due];
            end
            model_fill -= due;
            n_woken    += due;
            if (due > max_burst) max_burst = due;
            produced = due;
        end
    endtask

    // idle percentage for the current phase; phases follow accepted items
    function automatic int idle_pct(input bit sender_side, input int taken);
        if (taken < RANDOM_ITEMS * 2 / 5)
            return sender_side ? 21 : 55;
        else if (taken < RANDOM_ITEMS * 4 / 5)
            return sender_side ? 55 : 21;
        return 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_cnt < PRINT_CAP)
            $display("%0t mismatch on %s: got %0h, expected %0h (beat %0d)",
                     $realtime, what, got, want, events_seen);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Driver: slave side, fed from cmd_backlog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid  <= 1'b0;
            model_ticks =  '0;
            model_fill  =  0;
        end else begin
            new_events = 0;
            if (i_s_tvalid && o_s_tready) begin
                apply_timer_cmd(cur_cmd, new_events);
                events_predicted <= events_predicted + new_events;
                cmds_taken       <= cmds_taken + 1;
            end
            if (!i_s_tvalid || o_s_tready) begin
                // a held item waits until every answer so far has come back
                if (cmd_backlog.size() > 0 &&
                    !(cmd_backlog[0].drain_first &&
                      events_predicted + new_events != events_seen) &&
                    $urandom_range(99, 0) >= idle_pct(1'b1, cmds_taken)) begin
                    cur_cmd    =  cmd_backlog.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {cur_cmd.delay, cur_cmd.id};
                    i_s_tuser  <= cur_cmd.kind;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random backpressure on the master side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= ($urandom_range(99, 0) >= idle_pct(1'b0, cmds_taken));
    end

    // ------------------------------------------------------------------
    // Monitor: every result beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_timer_event want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            events_seen <= events_seen + 1;
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected beat", o_m_tdata[63:0], '0);
            end else begin
                want = pending_events.pop_front();
                if (o_m_tuser !== want.res)
                    report_mismatch("event_res", 64'(o_m_tuser), 64'(want.res));
                if (o_m_tdata[7:0] !== want.id)
                    report_mismatch("woken_id", 64'(o_m_tdata[7:0]), 64'(want.id));
                if (o_m_tdata[71:8] !== want.tick_now)
                    report_mismatch("tick_now", o_m_tdata[71:8], want.tick_now);
                if (o_m_tlast !== want.last)
                    report_mismatch("last_of_run", 64'(o_m_tlast), 64'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no beat on either side for too long ends the run
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_cmd(input logic kind, input logic [ID_W-1:0] id,
                           input logic [DELAY_W-1:0] delay, input logic hold);
        cmd_backlog.push_back('{kind, id, delay, hold});
    endtask

    // ticks carry random payload; the block must ignore it
    task automatic add_tick(input logic hold);
        add_cmd(KIND_TICK, ID_W'($urandom), $urandom, hold);
    endtask

    // mostly short sleeps so sleepers keep leaving; a few never wake
    function automatic logic [DELAY_W-1:0] pick_delay();
        int r;
        r = $urandom_range(99, 0);
        if (r < 2)  return $urandom;
        if (r < 20) return DELAY_W'($urandom_range(40, 0));
        return DELAY_W'($urandom_range(6, 0));
    endfunction

    initial begin
        int made;
        int burst;

        // tick with nobody due: count moves, no beat
        add_tick(1'b0);
        // zero delay: due at once, leaves on the next tick
        add_cmd(KIND_SLEEP, 8'h00, 32'd0, 1'b0);
        add_tick(1'b0);
        // fill all 16 slots with mixed 0/1 delays, equal wake times included;
        // ids 0x00..0xFF step 0x11
        for (int k = 0; k < QUEUE_DEPTH; k++)
            add_cmd(KIND_SLEEP, ID_W'(k * 17), (k % 3 == 0) ? 32'd0 : 32'd1, 1'b0);
        // queue full: rejected
        add_cmd(KIND_SLEEP, 8'h5A, 32'd0, 1'b0);
        // one tick drains the queue, earliest wake first; sent on a quiet bus
        add_tick(1'b1);
        // all-ones delay: stays queued for the rest of the run
        add_cmd(KIND_SLEEP, 8'hFF, 32'hFFFF_FFFF, 1'b0);
        add_tick(1'b0);

        // random part: bursts of sleeps that fill the queue, runs of ticks
        made = 0;
        while (made < RANDOM_ITEMS) begin
            if ($urandom_range(99, 0) < 55) begin
                burst = $urandom_range(12, 1);
                for (int k = 0; k < burst; k++)
                    add_cmd(KIND_SLEEP, ID_W'($urandom), pick_delay(),
                            (made + k == 0) || ($urandom_range(59, 0) == 0));
            end else begin
                burst = $urandom_range(8, 1);
                for (int k = 0; k < burst; k++)
                    add_tick(made + k == 0);
            end
            made += burst;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything on the bus, then every answer back
        while (cmd_backlog.size() > 0 || i_s_tvalid) @(negedge i_clk);
        while (events_predicted != events_seen) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (pending_events.size() != 0)
            report_mismatch("missing beats", 64'(0), 64'(pending_events.size()));

        $display("covered %0d items: %0d ticks, %0d sleeps queued, %0d rejected full",
                 cmds_taken, n_ticks, n_accepted, n_rejected);
        $display("%0d sleepers woken, up to %0d on one tick; %0d mismatches",
                 n_woken, max_burst, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sorted_wakeup_timer_queue.f @@
sv/swtq_pkg.sv
sv/swtq_cell.sv
sv/sorted_wakeup_timer_queue.sv
sv/swtq_checker.sv
bench/tb_sorted_wakeup_timer_queue.sv
